### rtl/wic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wic_pkg: shared types and constants of the windowed instruction cache
// Geometry, request and result codes, transaction layouts and the bus
// address translation used by the back end.
// ----------------------------------------------------------------------------
package wic_pkg;

  // Cache geometry (both powers of two)
  localparam int CACHE_BYTES = 512;
  localparam int LINE_BYTES  = 16;
  localparam int NLINES      = CACHE_BYTES / LINE_BYTES;
  localparam int OFFS_W      = $clog2(CACHE_BYTES);
  localparam int LINE_W      = $clog2(LINE_BYTES);
  localparam int LINE_IDX_W  = $clog2(NLINES);

  // Field widths
  localparam int ADDR_W  = 16;
  localparam int BANK_W  = 7;
  localparam int BUS_W   = 23;
  localparam int RAMM_W  = 17;
  localparam int BYTE_W  = 8;
  localparam int WAIT_W  = 3;
  localparam int CFG_W   = 23;
  localparam int CFGI_W  = 3;

  // Command queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // Reset values of the configuration registers
  localparam logic [BUS_W-1:0]  ROM_LIMIT_RST = 23'h1fffff;
  localparam logic [RAMM_W-1:0] RAM_LIMIT_RST = 17'h0ffff;

  // Register indexes
  localparam logic [CFGI_W-1:0] CFG_CACHE_BASE   = 3'd0;
  localparam logic [CFGI_W-1:0] CFG_PROGRAM_BANK = 3'd1;
  localparam logic [CFGI_W-1:0] CFG_SLOW_CLOCK   = 3'd2;
  localparam logic [CFGI_W-1:0] CFG_ROM_LIMIT    = 3'd3;
  localparam logic [CFGI_W-1:0] CFG_RAM_LIMIT    = 3'd4;

  // Request type codes
  localparam logic [2:0] REQ_FETCH   = 3'd0;
  localparam logic [2:0] REQ_FLUSH   = 3'd1;
  localparam logic [2:0] REQ_HOST_RD = 3'd2;
  localparam logic [2:0] REQ_HOST_WR = 3'd3;
  localparam logic [2:0] REQ_FILL    = 3'd4;

  // Result kind codes
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_MEMRD = 2'd1;
  localparam logic [1:0] KIND_ACK   = 2'd2;

  // Wait cycle charges
  localparam logic [WAIT_W-1:0] HIT_WAIT_SLOW = 3'd1;
  localparam logic [WAIT_W-1:0] HIT_WAIT_FAST = 3'd2;
  localparam logic [WAIT_W-1:0] MEM_WAIT_SLOW = 3'd5;
  localparam logic [WAIT_W-1:0] MEM_WAIT_FAST = 3'd6;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [BYTE_W-1:0] byte_out;
    logic              to_ram;
    logic [BUS_W-1:0]  mem_offset;
    logic              uncached;
    logic [WAIT_W-1:0] wait_cycles;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] cache_base;
    logic [BANK_W-1:0] program_bank;
    logic              slow_clock;
    logic [BUS_W-1:0]  rom_limit;
    logic [RAMM_W-1:0] ram_limit;
  } cfg_t;

  // Classified operations handed from front to back
  typedef enum logic [2:0] {
    OP_FETCH_WIN,
    OP_FETCH_UNC,
    OP_FLUSH,
    OP_HOST_RD,
    OP_HOST_WR,
    OP_FILL,
    OP_NOP
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e                  op;
    logic [OFFS_W-1:0]        offset;     // fetch offset or host cache index
    logic [ADDR_W-LINE_W-1:0] line_base;  // aligned bus line of a miss
    logic [ADDR_W-1:0]        address;
    logic [BYTE_W-1:0]        data;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_MISS,
    BK_RD_ISSUE,
    BK_RD_DATA
  } bk_state_e;

  typedef struct packed {
    logic             to_ram;
    logic [BUS_W-1:0] offset;
  } mem_tgt_t;

  // Map a bank address onto a masked ROM or RAM offset
  function automatic mem_tgt_t xlate(logic [BANK_W-1:0] bank, logic [ADDR_W-1:0] low,
                                     logic [BUS_W-1:0] rom_limit,
                                     logic [RAMM_W-1:0] ram_limit);
    logic [BUS_W-1:0] a;
    mem_tgt_t         r;
    a = {bank, low};
    if (!a[22]) begin
      // banks 00-3f: 32 KiB pages
      r.to_ram = 1'b0;
      r.offset = {2'b00, a[21:16], a[14:0]} & rom_limit;
    end else if (!a[21]) begin
      // banks 40-5f: linear ROM
      r.to_ram = 1'b0;
      r.offset = a & rom_limit;
    end else begin
      r.to_ram = 1'b1;
      r.offset = {{(BUS_W-RAMM_W){1'b0}}, a[RAMM_W-1:0] & ram_limit};
    end
    return r;
  endfunction

endpackage

### rtl/windowed_instruction_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_instruction_cache: top level
// Configuration registers, front classifier, command queue and back engine.
// ----------------------------------------------------------------------------
// After reset the block clears its 512-byte line store, one byte per cycle,
// and holds in_stall_o high while it does so; configuration writes are
// taken meanwhile. Transactions pass a two-entry command queue into a single
// back engine that handles one at a time. Flush, host write, acknowledged
// fill bytes and uncached fetches register their result as the engine takes
// them, one per cycle sustained while the result port does not stall. Cache
// hits and host reads go through the registered line store read; the fill
// byte that completes a line is written, then the pending byte is read. A
// miss issues its 16 read requests, one per cycle while the result port does
// not stall. Any stall on the result port stops the engine where it stands.
// ----------------------------------------------------------------------------
module windowed_instruction_cache (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [wic_pkg::CFGI_W-1:0] cfg_idx_i,
  input  logic [wic_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  wic_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output wic_pkg::out_item_t         out_item_o
);
  import wic_pkg::*;

  cfg_t cfg_q;
  logic clearing;
  logic fifo_push, fifo_full, fifo_pop, fifo_empty;
  cmd_t push_cmd, pop_cmd;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cache_base   <= '0;
      cfg_q.program_bank <= '0;
      cfg_q.slow_clock   <= 1'b0;
      cfg_q.rom_limit    <= ROM_LIMIT_RST;
      cfg_q.ram_limit    <= RAM_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CACHE_BASE:   cfg_q.cache_base   <= cfg_wdata_i[ADDR_W-1:0];
        CFG_PROGRAM_BANK: cfg_q.program_bank <= cfg_wdata_i[BANK_W-1:0];
        CFG_SLOW_CLOCK:   cfg_q.slow_clock   <= cfg_wdata_i[0];
        CFG_ROM_LIMIT:    cfg_q.rom_limit    <= cfg_wdata_i[BUS_W-1:0];
        CFG_RAM_LIMIT:    cfg_q.ram_limit    <= cfg_wdata_i[RAMM_W-1:0];
        default: ;
      endcase
    end
  end

  wic_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cfg_i       (cfg_q),
    .clearing_i  (clearing),
    .fifo_full_i (fifo_full),
    .push_o      (fifo_push),
    .cmd_o       (push_cmd)
  );

  wic_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (fifo_push),
    .push_cmd_i (push_cmd),
    .full_o     (fifo_full),
    .pop_i      (fifo_pop),
    .pop_cmd_o  (pop_cmd),
    .empty_o    (fifo_empty)
  );

  wic_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .fifo_empty_i (fifo_empty),
    .cmd_i        (pop_cmd),
    .pop_o        (fifo_pop),
    .clearing_o   (clearing),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

  // No transaction enters while the store is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !fifo_push)
    else $error("transaction accepted during store clear");

  // The queue is never written past its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push && fifo_full |-> fifo_pop)
    else $error("command queue overflow");

  // Only a miss request run spreads over several results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.kind != KIND_MEMRD) |-> out_item_o.last)
    else $error("data or acknowledge result without last flag");

  // An uncached request is always a single memory read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.uncached |->
      (out_item_o.kind == KIND_MEMRD) && out_item_o.last)
    else $error("malformed uncached request");

endmodule

### rtl/wic_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wic_cmd_fifo: command queue between front and back
// Short register FIFO that lets the front accept while the back is busy.
// ----------------------------------------------------------------------------
module wic_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wic_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output wic_pkg::cmd_t pop_cmd_o,
  output logic          empty_o
);
  import wic_pkg::*;

  cmd_t                  cmd_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_PTR_W:0]   cnt_q;

  assign full_o    = (cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign pop_cmd_o = cmd_q[rd_ptr_q];

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      cmd_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### rtl/wic_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wic_front: input acceptance and classification
// Computes the window offset, host index and miss line address of each
// incoming transaction and queues a classified command for the back end.
// ----------------------------------------------------------------------------
module wic_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  wic_pkg::in_item_t in_item_i,
  input  wic_pkg::cfg_t     cfg_i,
  input  logic              clearing_i,
  input  logic              fifo_full_i,
  output logic              push_o,
  output wic_pkg::cmd_t     cmd_o
);
  import wic_pkg::*;

  logic [ADDR_W-1:0] win_off;
  logic [ADDR_W-1:0] host_sum;
  logic [ADDR_W-1:0] line_sum;
  logic              in_win;

  // Hold off input while the queue is full or the store is being cleared
  assign in_stall_o = fifo_full_i || clearing_i;
  assign push_o     = in_valid_i && !in_stall_o;

  // Window offset and host index
  assign win_off  = in_item_i.address - cfg_i.cache_base;
  assign host_sum = in_item_i.address + cfg_i.cache_base;
  assign in_win   = (win_off[ADDR_W-1:OFFS_W] == '0);
  // Bus line of the missing cache line, rounded down to a line boundary
  assign line_sum = cfg_i.cache_base + {win_off[ADDR_W-1:LINE_W], {LINE_W{1'b0}}};

  // Classify the transaction
  always_comb begin
    cmd_o.address   = in_item_i.address;
    cmd_o.data      = in_item_i.data;
    cmd_o.line_base = line_sum[ADDR_W-1:LINE_W];
    cmd_o.offset    = host_sum[OFFS_W-1:0];
    case (in_item_i.req_type)
      REQ_FETCH: begin
        cmd_o.op     = in_win ? OP_FETCH_WIN : OP_FETCH_UNC;
        cmd_o.offset = win_off[OFFS_W-1:0];
      end
      REQ_FLUSH:   cmd_o.op = OP_FLUSH;
      REQ_HOST_RD: cmd_o.op = OP_HOST_RD;
      REQ_HOST_WR: cmd_o.op = OP_HOST_WR;
      REQ_FILL:    cmd_o.op = OP_FILL;
      default:     cmd_o.op = OP_NOP;
    endcase
  end

endmodule

### rtl/wic_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wic_back: cache execution engine
// Owns the line store, valid bits and fill state, carries out queued
// commands and drives the registered result stage.
// ----------------------------------------------------------------------------
module wic_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wic_pkg::cfg_t      cfg_i,
  input  logic               fifo_empty_i,
  input  wic_pkg::cmd_t      cmd_i,
  output logic               pop_o,
  output logic               clearing_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output wic_pkg::out_item_t out_item_o
);
  import wic_pkg::*;

  bk_state_e                state_q, state_d;
  logic [OFFS_W-1:0]        clr_cnt_q, clr_cnt_d;
  logic [NLINES-1:0]        valid_q, valid_d;
  logic                     filling_q, filling_d;
  logic [LINE_IDX_W-1:0]    fill_line_q, fill_line_d;
  logic [LINE_W-1:0]        fill_cnt_q, fill_cnt_d;
  logic [OFFS_W-1:0]        pend_off_q, pend_off_d;
  logic [ADDR_W-LINE_W-1:0] miss_base_q, miss_base_d;
  logic [LINE_W-1:0]        req_cnt_q, req_cnt_d;
  logic [WAIT_W-1:0]        rd_wait_q, rd_wait_d;
  out_item_t                out_q, out_d;
  logic                     out_valid_q;
  logic                     emit;

  logic [BYTE_W-1:0]        mem_q [CACHE_BYTES];
  logic [BYTE_W-1:0]        rd_data_q;
  logic                     mem_we, mem_re;
  logic [OFFS_W-1:0]        mem_waddr, mem_raddr;
  logic [BYTE_W-1:0]        mem_wdata;

  logic                     emit_ok;
  logic [WAIT_W-1:0]        hit_wait, mem_wait;
  logic [LINE_IDX_W-1:0]    cmd_line;
  mem_tgt_t                 tgt_unc, tgt_miss;

  assign emit_ok  = !out_valid_q || !out_stall_i;
  assign hit_wait = cfg_i.slow_clock ? HIT_WAIT_SLOW : HIT_WAIT_FAST;
  assign mem_wait = cfg_i.slow_clock ? MEM_WAIT_SLOW : MEM_WAIT_FAST;
  assign cmd_line = cmd_i.offset[OFFS_W-1:LINE_W];
  assign tgt_unc  = xlate(cfg_i.program_bank, cmd_i.address, cfg_i.rom_limit,
                          cfg_i.ram_limit);
  assign tgt_miss = xlate(cfg_i.program_bank, {miss_base_q, req_cnt_q}, cfg_i.rom_limit,
                          cfg_i.ram_limit);

  assign clearing_o  = (state_q == BK_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Sequence commands and build results
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    valid_d     = valid_q;
    filling_d   = filling_q;
    fill_line_d = fill_line_q;
    fill_cnt_d  = fill_cnt_q;
    pend_off_d  = pend_off_q;
    miss_base_d = miss_base_q;
    req_cnt_d   = req_cnt_q;
    rd_wait_d   = rd_wait_q;
    out_d       = '0;
    out_d.kind  = KIND_ACK;
    out_d.last  = 1'b1;
    emit        = 1'b0;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = cmd_i.offset;
    mem_wdata   = cmd_i.data;
    mem_re      = 1'b0;
    mem_raddr   = cmd_i.offset;

    case (state_q)
      BK_CLEAR: begin
        // Zero one byte of the store per cycle after reset
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (&clr_cnt_q) begin
          state_d = BK_IDLE;
        end
      end

      BK_IDLE: begin
        if (!fifo_empty_i && emit_ok) begin
          pop_o = 1'b1;
          case (cmd_i.op)
            OP_FETCH_WIN: begin
              if (valid_q[cmd_line]) begin
                mem_re    = 1'b1;
                rd_wait_d = hit_wait;
                state_d   = BK_RD_DATA;
              end else begin
                // Start a line fill, abandoning any fill in progress
                filling_d   = 1'b1;
                fill_line_d = cmd_line;
                fill_cnt_d  = '0;
                pend_off_d  = cmd_i.offset;
                miss_base_d = cmd_i.line_base;
                req_cnt_d   = '0;
                state_d     = BK_MISS;
              end
            end
            OP_FETCH_UNC: begin
              emit             = 1'b1;
              out_d.kind       = KIND_MEMRD;
              out_d.to_ram     = tgt_unc.to_ram;
              out_d.mem_offset = tgt_unc.offset;
              out_d.uncached   = 1'b1;
              out_d.wait_cycles = mem_wait;
            end
            OP_FLUSH: begin
              valid_d = '0;
              emit    = 1'b1;
            end
            OP_HOST_RD: begin
              mem_re    = 1'b1;
              rd_wait_d = '0;
              state_d   = BK_RD_DATA;
            end
            OP_HOST_WR: begin
              mem_we = 1'b1;
              if (&cmd_i.offset[LINE_W-1:0]) begin
                valid_d[cmd_line] = 1'b1;
              end
              emit = 1'b1;
            end
            OP_FILL: begin
              if (filling_q) begin
                mem_we     = 1'b1;
                mem_waddr  = {fill_line_q, fill_cnt_q};
                fill_cnt_d = fill_cnt_q + 1'b1;
                if (&fill_cnt_q) begin
                  // Line complete: mark it and return the pending byte
                  valid_d[fill_line_q] = 1'b1;
                  filling_d = 1'b0;
                  rd_wait_d = '0;
                  state_d   = BK_RD_ISSUE;
                end else begin
                  emit = 1'b1;
                end
              end else begin
                emit = 1'b1;
              end
            end
            default: emit = 1'b1;
          endcase
        end
      end

      BK_MISS: begin
        // Issue one read request per byte of the line
        if (emit_ok) begin
          emit              = 1'b1;
          out_d.kind        = KIND_MEMRD;
          out_d.to_ram      = tgt_miss.to_ram;
          out_d.mem_offset  = tgt_miss.offset;
          out_d.wait_cycles = mem_wait;
          out_d.last        = &req_cnt_q;
          req_cnt_d         = req_cnt_q + 1'b1;
          if (&req_cnt_q) begin
            state_d = BK_IDLE;
          end
        end
      end

      BK_RD_ISSUE: begin
        mem_re    = 1'b1;
        mem_raddr = pend_off_q;
        state_d   = BK_RD_DATA;
      end

      BK_RD_DATA: begin
        if (emit_ok) begin
          emit              = 1'b1;
          out_d.kind        = KIND_DATA;
          out_d.byte_out    = rd_data_q;
          out_d.wait_cycles = rd_wait_q;
          state_d           = BK_IDLE;
        end
      end

      default: state_d = BK_IDLE;
    endcase
  end

  // Line store with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      clr_cnt_q   <= '0;
      valid_q     <= '0;
      filling_q   <= 1'b0;
      fill_line_q <= '0;
      fill_cnt_q  <= '0;
      pend_off_q  <= '0;
      miss_base_q <= '0;
      req_cnt_q   <= '0;
      rd_wait_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      valid_q     <= valid_d;
      filling_q   <= filling_d;
      fill_line_q <= fill_line_d;
      fill_cnt_q  <= fill_cnt_d;
      pend_off_q  <= pend_off_d;
      miss_base_q <= miss_base_d;
      req_cnt_q   <= req_cnt_d;
      rd_wait_q   <= rd_wait_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
